>>> rtl/core/vslr_pkg.sv
// Shared types, sizes and codes for the sparse-lag VARMA recursion core.
package vslr_pkg;

  localparam int unsigned Series   = 4;
  localparam int unsigned ArTaps   = 4;
  localparam int unsigned MaTaps   = 4;
  localparam int unsigned History  = 16;
  localparam int unsigned LagLimit = 16;

  localparam int unsigned SerW  = $clog2(Series);
  localparam int unsigned TapW  = $clog2(ArTaps);
  localparam int unsigned HistW = $clog2(History);
  localparam int unsigned CoefW = $clog2(ArTaps * Series * Series);
  localparam int unsigned RowW  = $clog2(History * Series);

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_SEED = 2'd1,
    OP_STEP = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    WK_AR_COEF = 3'd0,
    WK_MA_COEF = 3'd1,
    WK_AR_LAG  = 3'd2,
    WK_MA_LAG  = 3'd3,
    WK_DRIFT   = 3'd4
  } word_kind_e;

  typedef enum logic [1:0] {
    REG_SERIES_COUNT = 2'd0,
    REG_AR_TAP_COUNT = 2'd1,
    REG_MA_TAP_COUNT = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_INIT,
    ST_MAC,
    ST_EMIT,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  word_kind;
    logic [1:0]  tap;
    logic [1:0]  series;
    logic [1:0]  source_series;
    logic [4:0]  history_age;
    logic signed [31:0] value;
    logic signed [31:0] innovation;
    logic signed [31:0] linpred;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  series_res;
    logic signed [31:0] trend;
    logic        last;
  } out_beat_t;

  // Saturate a 64-bit value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) r = 32'sh7fffffff;
    else if (x < -64'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  // Clip a lag or age to 1..LagLimit.
  function automatic logic [4:0] clip_lag(input logic signed [31:0] v);
    logic [4:0] r;
    if (v < 32'sd1) r = 5'd1;
    else if (v > 32'(LagLimit)) r = 5'(LagLimit);
    else r = v[4:0];
    return r;
  endfunction

endpackage

>>> rtl/core/vslr_stream_if.sv
// Valid/ready stream interface carrying one beat of payload.
interface vslr_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/vslr_mac.sv
// Shared multiply-accumulate unit: product, floor shift by 16, 64-bit accumulate.
module vslr_mac (
  input  logic               clk_i,
  input  logic               load_i,
  input  logic signed [63:0] load_val_i,
  input  logic               mac_i,
  input  logic signed [31:0] coef_i,
  input  logic signed [31:0] data_i,
  output logic signed [63:0] acc_o
);
  logic signed [63:0] prod_q, acc_q;
  logic               mac_q;

  // The product is registered before the add; arithmetic shift floors.
  always_ff @(posedge clk_i) begin
    prod_q <= (64'(coef_i) * 64'(data_i)) >>> 16;
    mac_q  <= mac_i;
    if (load_i) begin
      acc_q <= load_val_i;
    end else if (mac_q) begin
      acc_q <= acc_q + prod_q;
    end
  end

  assign acc_o = acc_q;
endmodule

>>> rtl/core/varma_sparse_lag_recursion_core.sv
// Top level of the sparse-lag VARMA recursion core.
// Every accepted beat sets a hold register that keeps the input not ready
// until it clears. A step beat for a series other than the last in use is
// only stored. The closing step beat runs one shared multiplier over every
// (series, tap, source) term, with a read phase and a multiply phase per
// term, then emits one trend beat per series in use and pushes a history
// row of Series entries; output stalls hold it back. After reset the
// coefficient and history memories are cleared one entry per cycle
// (History*Series = 64 entries) before the first beat is accepted.
module varma_sparse_lag_recursion_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [2:0]    cfg_data_i,
  vslr_stream_if.sink   in_if,
  vslr_stream_if.source out_if
);
  import vslr_pkg::*;

  // Memories and small tables.
  logic signed [31:0] ar_coef_mem [ArTaps*Series*Series];
  logic signed [31:0] ma_coef_mem [MaTaps*Series*Series];
  logic signed [31:0] cen_mem [History*Series];
  logic signed [31:0] inn_mem [History*Series];
  logic [4:0]         ar_lag_q [ArTaps];
  logic [4:0]         ma_lag_q [MaTaps];
  logic signed [31:0] drift_q [Series];
  logic signed [31:0] cur_inn_q [Series];
  logic signed [31:0] cur_lp_q [Series];
  logic signed [31:0] trend_q [Series];
  logic [HistW-1:0]   head_q;
  logic [2:0]         n_cfg_q, ar_cfg_q, ma_cfg_q;

  state_e             state_q, state_d;
  in_beat_t           beat;
  logic [RowW-1:0]    clr_q;
  logic [SerW-1:0]    i_q, j_q;
  logic [TapW+1:0]    k_q;
  logic               ph_q;
  logic [1:0]         init_q;
  logic signed [31:0] coef_rd_q, hist_rd_q;
  logic               mac_go_q;

  // Clamped configuration.
  logic [2:0] n_eff, nar, nma;
  logic [SerW-1:0] last_ser;
  always_comb begin
    n_eff = (n_cfg_q == 3'd0) ? 3'd1 : (n_cfg_q > 3'(Series)) ? 3'(Series) : n_cfg_q;
    nar   = (ar_cfg_q > 3'(ArTaps)) ? 3'(ArTaps) : ar_cfg_q;
    nma   = (ma_cfg_q > 3'(MaTaps)) ? 3'(MaTaps) : ma_cfg_q;
    last_ser = SerW'(n_eff - 3'd1);
  end

  assign beat = in_if.data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_cfg_q  <= 3'd1;
      ar_cfg_q <= 3'd0;
      ma_cfg_q <= 3'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SERIES_COUNT: n_cfg_q  <= cfg_data_i;
        REG_AR_TAP_COUNT: ar_cfg_q <= cfg_data_i;
        REG_MA_TAP_COUNT: ma_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Current term: tap index within AR then MA, and addresses.
  logic            is_ma;
  logic [TapW-1:0] tk;
  logic [4:0]      lag;
  logic [HistW-1:0] lag_row;
  logic [CoefW-1:0] caddr;
  logic [RowW-1:0]  haddr;
  always_comb begin
    is_ma = (k_q >= (TapW+2)'(nar));
    tk    = is_ma ? TapW'(k_q - (TapW+2)'(nar)) : TapW'(k_q);
    lag   = is_ma ? ma_lag_q[tk] : ar_lag_q[tk];
    lag_row = head_q - HistW'(lag);
    caddr = {tk, i_q, j_q};
    haddr = {lag_row, j_q};
  end

  logic [TapW+1:0] taps_tot;
  assign taps_tot = (TapW+2)'(nar) + (TapW+2)'(nma);

  // Accumulator initial value.
  logic signed [63:0] init_val;
  assign init_val = 64'(cur_lp_q[i_q]) + 64'(drift_q[i_q]) + 64'(cur_inn_q[i_q]);

  logic signed [63:0] acc;
  logic acc_load;
  assign acc_load = (state_q == ST_INIT) && (init_q == 2'd0);
  vslr_mac u_mac (
    .clk_i      (clk_i),
    .load_i     (acc_load),
    .load_val_i (init_val),
    .mac_i      (mac_go_q),
    .coef_i     (coef_rd_q),
    .data_i     (hist_rd_q),
    .acc_o      (acc)
  );

  // Handshake signals; a new output beat is only issued once the last one left.
  logic out_v_q;
  out_beat_t out_q;
  logic hold_q;
  logic emit_go;
  assign in_if.ready = (state_q == ST_IDLE) && !hold_q && !out_v_q;
  assign out_if.valid = out_v_q;
  assign out_if.data  = out_q;
  assign emit_go = (state_q == ST_EMIT) && (init_q == 2'd3) && !out_v_q;

  logic in_fire;
  assign in_fire = in_if.valid && in_if.ready;

  // Sequencer next state.
  logic last_term;
  assign last_term = (k_q == taps_tot - 1'b1) && (j_q == last_ser) && ph_q;
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == RowW'(History*Series-1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_fire && beat.op == OP_STEP && beat.series == last_ser) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: if (init_q == 2'd3) state_d = (taps_tot == '0) ? ST_EMIT : ST_MAC;
      ST_MAC:  if (last_term) state_d = ST_EMIT;
      ST_EMIT: if (emit_go) state_d = (i_q == last_ser) ? ST_PUSH : ST_INIT;
      ST_PUSH: if (i_q == SerW'(Series-1) && !out_v_q) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      head_q  <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      ph_q    <= 1'b0;
      init_q  <= '0;
      mac_go_q <= 1'b0;
      out_v_q <= 1'b0;
      out_q   <= '0;
      hold_q  <= 1'b0;
      for (int s = 0; s < Series; s++) begin
        drift_q[s]   <= '0;
        cur_inn_q[s] <= '0;
        cur_lp_q[s]  <= '0;
        trend_q[s]   <= '0;
      end
      for (int t = 0; t < ArTaps; t++) ar_lag_q[t] <= 5'd1;
      for (int t = 0; t < MaTaps; t++) ma_lag_q[t] <= 5'd1;
    end else begin
      state_q  <= state_d;
      mac_go_q <= 1'b0;
      hold_q   <= in_fire;
      if (emit_go) out_v_q <= 1'b1;
      else if (out_v_q && out_if.ready) out_v_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: clr_q <= clr_q + 1'b1;
        ST_IDLE: begin
          i_q <= '0;
          if (in_fire) begin
            unique case (beat.op)
              OP_LOAD: begin
                if (beat.word_kind == WK_AR_LAG) ar_lag_q[beat.tap] <= clip_lag(beat.value);
                if (beat.word_kind == WK_MA_LAG) ma_lag_q[beat.tap] <= clip_lag(beat.value);
                if (beat.word_kind == WK_DRIFT) drift_q[beat.series] <= beat.value;
              end
              OP_STEP: begin
                cur_inn_q[beat.series] <= beat.innovation;
                cur_lp_q[beat.series]  <= beat.linpred;
              end
              default: ;
            endcase
          end
        end
        ST_INIT: begin
          // The two-bit count wraps back to zero as the state is left.
          init_q <= init_q + 1'b1;
          j_q <= '0;
          k_q <= '0;
          ph_q <= 1'b0;
        end
        ST_MAC: begin
          // Phase 0 reads memories, phase 1 issues the multiply.
          ph_q <= ~ph_q;
          if (ph_q) begin
            mac_go_q <= 1'b1;
            if (j_q == last_ser) begin
              j_q <= '0;
              k_q <= k_q + 1'b1;
            end else begin
              j_q <= j_q + 1'b1;
            end
          end
        end
        ST_EMIT: begin
          // Wait for the pipelined accumulate to settle and the output to be free.
          if (init_q != 2'd3) begin
            init_q <= init_q + 1'b1;
          end else if (!out_v_q) begin
            init_q <= '0;
            trend_q[i_q] <= sat32(acc);
            out_q.series_res <= i_q;
            out_q.trend <= sat32(acc);
            out_q.last <= (i_q == last_ser);
            i_q <= (i_q == last_ser) ? '0 : i_q + 1'b1;
          end
        end
        ST_PUSH: begin
          if (!out_v_q) begin
            i_q <= i_q + 1'b1;
            if (i_q == SerW'(Series-1)) head_q <= head_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Coefficient memories: cleared after reset, written by load beats, read by the sequencer.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      ar_coef_mem[CoefW'(clr_q)] <= '0;
      ma_coef_mem[CoefW'(clr_q)] <= '0;
    end else begin
      if (in_fire && beat.op == OP_LOAD && beat.word_kind == WK_AR_COEF) begin
        ar_coef_mem[{beat.tap, beat.series, beat.source_series}] <= beat.value;
      end
      if (in_fire && beat.op == OP_LOAD && beat.word_kind == WK_MA_COEF) begin
        ma_coef_mem[{beat.tap, beat.series, beat.source_series}] <= beat.value;
      end
    end
    coef_rd_q <= is_ma ? ma_coef_mem[caddr] : ar_coef_mem[caddr];
  end

  // History memories: cleared after reset, seeded, pushed, and read per term.
  logic [HistW-1:0] seed_row;
  logic signed [31:0] push_cen;
  logic in_use;
  assign seed_row = head_q - HistW'(clip_lag(32'(beat.history_age)));
  assign in_use   = ({1'b0, i_q} < 3'(n_eff));
  assign push_cen = sat32(64'(trend_q[i_q]) - 64'(cur_lp_q[i_q]));
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      cen_mem[clr_q] <= '0;
      inn_mem[clr_q] <= '0;
    end else if (in_fire && beat.op == OP_SEED) begin
      cen_mem[{seed_row, beat.series}] <= sat32(64'(beat.value) - 64'(beat.linpred));
      inn_mem[{seed_row, beat.series}] <= beat.innovation;
    end else if (state_q == ST_PUSH && !out_v_q) begin
      cen_mem[{head_q, i_q}] <= in_use ? push_cen : '0;
      inn_mem[{head_q, i_q}] <= in_use ? cur_inn_q[i_q] : '0;
    end
    hist_rd_q <= is_ma ? inn_mem[haddr] : cen_mem[haddr];
  end
endmodule

>>> tb/tb_varma_sparse_lag_recursion_core.sv
// Self-checking testbench for the sparse-lag VARMA recursion core.
module tb_varma_sparse_lag_recursion_core;
  timeunit 1ns;
  timeprecision 1ps;
  import vslr_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [2:0] WK_SPARE = 3'd7;
  localparam int QUIET_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 300;

  // Tracks the expected trend beats and compares the accepted output beats.
  class trend_scoreboard;
    logic signed [31:0] ar_coef [ArTaps][Series][Series];
    logic signed [31:0] ma_coef [MaTaps][Series][Series];
    logic [4:0] ar_lag [ArTaps];
    logic [4:0] ma_lag [MaTaps];
    logic signed [31:0] drift [Series];
    logic signed [31:0] centred [History][Series];
    logic signed [31:0] innov_hist [History][Series];
    logic signed [31:0] cur_innov [Series];
    logic signed [31:0] cur_lp [Series];
    int unsigned head;
    logic [2:0] series_reg, ar_reg, ma_reg;
    out_beat_t pending_trends[$];
    int errors, checked;

    function new();
      for (int t = 0; t < 4; t++) begin
        ar_lag[t] = 5'd1;
        ma_lag[t] = 5'd1;
        for (int i = 0; i < Series; i++)
          for (int j = 0; j < Series; j++) begin
            ar_coef[t][i][j] = '0;
            ma_coef[t][i][j] = '0;
          end
      end
      for (int r = 0; r < History; r++)
        for (int i = 0; i < Series; i++) begin
          centred[r][i] = '0;
          innov_hist[r][i] = '0;
        end
      for (int i = 0; i < Series; i++) begin
        drift[i] = '0;
        cur_innov[i] = '0;
        cur_lp[i] = '0;
      end
      head = 0;
      series_reg = 3'd1;
      ar_reg = 3'd0;
      ma_reg = 3'd0;
      errors = 0;
      checked = 0;
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    function void write_reg(reg_idx_e idx, logic [2:0] v);
      case (idx)
        REG_SERIES_COUNT: series_reg = v;
        REG_AR_TAP_COUNT: ar_reg = v;
        REG_MA_TAP_COUNT: ma_reg = v;
        default: ;
      endcase
    endfunction

    function longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function logic [4:0] limit_lag(longint v);
      if (v < 1) return 5'd1;
      if (v > LagLimit) return 5'(LagLimit);
      return 5'(v);
    endfunction

    // Product in Q16.16, rounded toward minus infinity.
    function longint fix_mul(longint a, longint b);
      longint p;
      p = a * b;
      return p >>> 16;
    endfunction

    function int unsigned row_back(int unsigned age);
      return (head + History - (age % History)) % History;
    endfunction

    // Applies one accepted input beat and queues the trend beats it causes.
    function void note_input(in_beat_t b);
      int unsigned n, nar, nma, row;
      longint acc;
      longint trends [Series];
      out_beat_t o;
      case (b.op)
        OP_LOAD: begin
          case (b.word_kind)
            WK_AR_COEF: ar_coef[b.tap][b.series][b.source_series] = b.value;
            WK_MA_COEF: ma_coef[b.tap][b.series][b.source_series] = b.value;
            WK_AR_LAG:  ar_lag[b.tap] = limit_lag(b.value);
            WK_MA_LAG:  ma_lag[b.tap] = limit_lag(b.value);
            WK_DRIFT:   drift[b.series] = b.value;
            default: ;
          endcase
        end
        OP_SEED: begin
          row = row_back(limit_lag(b.history_age));
          centred[row][b.series] = 32'(clamp32(longint'(b.value) - longint'(b.linpred)));
          innov_hist[row][b.series] = b.innovation;
        end
        OP_STEP: begin
          cur_innov[b.series] = b.innovation;
          cur_lp[b.series] = b.linpred;
          n = (series_reg < 1) ? 1 : (series_reg > Series) ? Series : series_reg;
          if (b.series == n - 1) begin
            nar = (ar_reg > ArTaps) ? ArTaps : ar_reg;
            nma = (ma_reg > MaTaps) ? MaTaps : ma_reg;
            for (int i = 0; i < n; i++) begin
              acc = longint'(cur_lp[i]) + longint'(drift[i]) + longint'(cur_innov[i]);
              for (int k = 0; k < nar; k++) begin
                row = row_back(ar_lag[k]);
                for (int j = 0; j < n; j++)
                  acc += fix_mul(ar_coef[k][i][j], centred[row][j]);
              end
              for (int k = 0; k < nma; k++) begin
                row = row_back(ma_lag[k]);
                for (int j = 0; j < n; j++)
                  acc += fix_mul(ma_coef[k][i][j], innov_hist[row][j]);
              end
              trends[i] = clamp32(acc);
            end
            // Push the new row; series out of use get zero columns.
            for (int i = 0; i < Series; i++) begin
              if (i < n) begin
                centred[head][i] = 32'(clamp32(trends[i] - longint'(cur_lp[i])));
                innov_hist[head][i] = cur_innov[i];
              end else begin
                centred[head][i] = '0;
                innov_hist[head][i] = '0;
              end
            end
            head = (head + 1) % History;
            for (int i = 0; i < n; i++) begin
              o.series_res = 2'(i);
              o.trend = 32'(trends[i]);
              o.last = (i == n - 1);
              pending_trends.push_back(o);
            end
          end
        end
        default: ;
      endcase
    endfunction

    task check_result(out_beat_t got);
      out_beat_t want;
      checked++;
      if (pending_trends.size() == 0) begin
        report($sformatf("unexpected beat series %0d trend %0d", got.series_res, got.trend));
      end else begin
        want = pending_trends.pop_front();
        if (got.series_res !== want.series_res)
          report($sformatf("series_res %0d, wanted %0d", got.series_res, want.series_res));
        if (got.trend !== want.trend)
          report($sformatf("trend of series %0d: %0d, wanted %0d",
                           want.series_res, got.trend, want.trend));
        if (got.last !== want.last)
          report($sformatf("last of series %0d: %0b, wanted %0b",
                           want.series_res, got.last, want.last));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [2:0] cfg_data_i = '0;
  bit idle_on = 1'b1;
  int accepted = 0;
  int quiet = 0;

  vslr_stream_if #(.T(in_beat_t)) in_ch ();
  vslr_stream_if #(.T(out_beat_t)) out_ch ();

  trend_scoreboard sb = new();

  varma_sparse_lag_recursion_core u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Output side: check accepted beats and stall at random while idle_on is set.
  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    out_ch.ready <= rst_ni && (!idle_on || $urandom_range(99) >= 30);
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_beat(in_beat_t b);
    int gap;
    gap = (idle_on && $urandom_range(99) < 30) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= b;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    sb.note_input(b);
    accepted++;
  endtask

  // Wait until all trend beats are in and the core has finished any quiet work.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_trends.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Drives one register write for a cycle; the caller drops the enable.
  task automatic write_cfg(reg_idx_e idx, logic [2:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.write_reg(idx, v);
  endtask

  task automatic set_regs(logic [2:0] n, logic [2:0] a, logic [2:0] m);
    write_cfg(REG_SERIES_COUNT, n);
    write_cfg(REG_AR_TAP_COUNT, a);
    write_cfg(REG_MA_TAP_COUNT, m);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly modest Q16.16 values, sometimes the full range.
  function automatic logic signed [31:0] pick_q(int span);
    case ($urandom_range(9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom();
      default: return $signed($urandom_range(0, 2 * span)) - span;
    endcase
  endfunction

  function automatic in_beat_t mk(logic [1:0] op, logic [2:0] kind, int tap, int ser,
                                  int src, int age, logic signed [31:0] val,
                                  logic signed [31:0] inn, logic signed [31:0] lp);
    in_beat_t b;
    b.op = op;
    b.word_kind = kind;
    b.tap = 2'(tap);
    b.series = 2'(ser);
    b.source_series = 2'(src);
    b.history_age = 5'(age);
    b.value = val;
    b.innovation = inn;
    b.linpred = lp;
    return b;
  endfunction

  function automatic in_beat_t noise_beat();
    in_beat_t b;
    b.op = 2'($urandom);
    b.word_kind = 3'($urandom);
    b.tap = 2'($urandom);
    b.series = 2'($urandom);
    b.source_series = 2'($urandom);
    b.history_age = 5'($urandom);
    b.value = $urandom();
    b.innovation = $urandom();
    b.linpred = $urandom();
    return b;
  endfunction

  task automatic send_load();
    logic [2:0] kind;
    logic signed [31:0] val;
    kind = 3'($urandom_range(WK_DRIFT));
    if (kind == WK_AR_LAG || kind == WK_MA_LAG)
      val = ($urandom_range(3) == 0) ? $signed($urandom()) : $signed($urandom_range(0, 18));
    else
      val = pick_q(32'h18000);
    send_beat(mk(OP_LOAD, kind, $urandom_range(3), $urandom_range(3),
                 $urandom_range(3), 0, val, 0, 0));
  endtask

  task automatic send_seed();
    send_beat(mk(OP_SEED, 3'($urandom), $urandom_range(3), $urandom_range(3),
                 $urandom_range(3), $urandom_range(31), pick_q(32'h40000),
                 pick_q(32'h20000), pick_q(32'h40000)));
  endtask

  // One time step: an element for every series in use, in order.
  task automatic send_step(int n);
    for (int s = 0; s < n; s++)
      send_beat(mk(OP_STEP, 3'($urandom), $urandom_range(3), s, $urandom_range(3), 0,
                   $urandom(), pick_q(32'h20000), pick_q(32'h40000)));
  endtask

  initial begin
    int n, steps;
    logic [2:0] cfg_n, cfg_a, cfg_m;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: clipped lags, extreme coefficients, seed ages, odd codes.
    set_regs(3'd4, 3'd4, 3'd4);
    send_beat(mk(OP_LOAD, WK_AR_LAG, 0, 0, 0, 0, 32'sd0, 0, 0));
    send_beat(mk(OP_LOAD, WK_AR_LAG, 1, 0, 0, 0, 32'sd20, 0, 0));
    send_beat(mk(OP_LOAD, WK_MA_LAG, 2, 0, 0, 0, -32'sd5, 0, 0));
    send_beat(mk(OP_LOAD, WK_MA_LAG, 3, 0, 0, 0, 32'sd3, 0, 0));
    send_beat(mk(OP_LOAD, WK_AR_COEF, 0, 3, 0, 0, 32'sh80000000, 0, 0));
    send_beat(mk(OP_LOAD, WK_AR_COEF, 1, 0, 3, 0, 32'sh7fffffff, 0, 0));
    send_beat(mk(OP_LOAD, WK_MA_COEF, 3, 2, 1, 0, 32'sh00010000, 0, 0));
    send_beat(mk(OP_LOAD, WK_DRIFT, 0, 1, 0, 0, 32'sh7fffffff, 0, 0));
    send_beat(mk(OP_SEED, WK_AR_COEF, 0, 0, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh80000000));
    send_beat(mk(OP_SEED, WK_AR_COEF, 0, 3, 0, 31, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff));
    send_beat(mk(OP_SEED, WK_AR_COEF, 0, 1, 0, 16, 32'sh00030000, -32'sh10000, 0));
    send_beat(mk(OP_SEED, WK_AR_COEF, 0, 2, 0, 3, -32'sh20000, 32'sh8000, 32'sh1000));
    send_beat(mk(OP_SPARE, WK_SPARE, 3, 3, 3, 31, -1, -1, -1));
    send_beat(mk(OP_LOAD, WK_SPARE, 2, 2, 2, 0, 32'sh12345678, 0, 0));
    send_beat(mk(OP_STEP, WK_AR_COEF, 0, 2, 0, 0, 0, 32'sh7fffffff, 32'sh7fffffff));
    send_step(4);
    send_beat(mk(OP_STEP, WK_AR_COEF, 0, 0, 0, 0, 0, 32'sh80000000, 32'sh80000000));
    send_beat(mk(OP_STEP, WK_AR_COEF, 0, 1, 0, 0, 0, 32'sh80000000, 32'sh80000000));
    send_beat(mk(OP_STEP, WK_AR_COEF, 0, 2, 0, 0, 0, 32'sh80000000, 32'sh80000000));
    send_beat(mk(OP_STEP, WK_AR_COEF, 0, 3, 0, 0, 0, 32'sh80000000, 32'sh80000000));
    drain();

    // Random part in phases, each under its own register setting.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin cfg_n = 3'd0; cfg_a = 3'd0; cfg_m = 3'd0; end
        1: begin cfg_n = 3'd7; cfg_a = 3'd7; cfg_m = 3'd7; end
        2: begin cfg_n = 3'd1; cfg_a = 3'd4; cfg_m = 3'd0; end
        default: begin
          cfg_n = 3'($urandom);
          cfg_a = 3'($urandom);
          cfg_m = 3'($urandom);
        end
      endcase
      set_regs(cfg_n, cfg_a, cfg_m);
      n = (cfg_n < 1) ? 1 : (cfg_n > Series) ? Series : cfg_n;
      idle_on = (ph != 4);
      steps = 0;
      while (steps < 5) begin
        case ($urandom_range(9))
          0, 1: send_load();
          2: send_seed();
          3: send_beat(noise_beat());
          default: begin
            send_step(n);
            steps++;
          end
        endcase
        // In phase 3 after the second step, hold the sender off until the core has delivered everything.
        if (ph == 3 && steps == 2 && sb.pending_trends.size() != 0) begin
          in_ch.valid <= 1'b0;
          while (sb.pending_trends.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    $display("Covered %0d accepted input beats and %0d trend beats over 9 register settings.",
             accepted, sb.checked);
    if (sb.errors == 0 && sb.pending_trends.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
